[hw/rtl/spo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spo_pkg;

    localparam int MaxProj   = 8;
    localparam int MaxHits   = 64;
    localparam int IndexBits = 20;
    localparam int FracBits  = 24;
    localparam int ProjBits  = $clog2(MaxProj);
    localparam int HitBits   = $clog2(MaxHits);

    localparam logic [1:0] ActProj   = 2'd0;
    localparam logic [1:0] ActMatrix = 2'd1;
    localparam logic [1:0] ActSample = 2'd2;

    localparam logic CfgProj = 1'b0;
    localparam logic CfgHits = 1'b1;

    localparam logic signed [63:0] CoefMax = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] CoefMin = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

    // one multiply-accumulate request travelling along the cell chain
    typedef struct packed {
        logic                   vld;
        logic                   clr;
        logic                   wide;
        logic                   done;
        logic [ProjBits-1:0]    lane;
        logic signed [47:0]     a;
        logic signed [31:0]     b;
    } mac_op_t;

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
        if (v > CoefMax)
            return CoefMax;
        else if (v < CoefMin)
            return CoefMin;
        else
            return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/spo_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module spo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/spo_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// one accumulator cell: owns one coefficient, passes the request on
module spo_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [spo_pkg::ProjBits-1:0] id,
    input  wire spo_pkg::mac_op_t            op_in,
    input  wire logic signed [79:0]         prod_in,
    output spo_pkg::mac_op_t                 op_out,
    output logic signed [79:0]              prod_out,
    output logic signed [63:0]              acc
);
    logic signed [63:0] acc_reg, acc_next;
    spo_pkg::mac_op_t   op_reg;
    logic signed [79:0] prod_reg;

    // accumulate when the request addresses this cell
    always_comb
    begin
        acc_next = acc_reg;
        if (op_in.vld && op_in.lane == id)
        begin
            if (op_in.clr)
                acc_next = prod_in[63:0];
            else
                acc_next = acc_reg + prod_in[63:0];
            if (op_in.done)
                acc_next = spo_pkg::clamp48(acc_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            op_reg  <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            op_reg  <= op_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_in;
    end

    assign op_out   = op_reg;
    assign prod_out = prod_reg;
    assign acc      = acc_reg;
endmodule
`default_nettype wire

[hw/rtl/separable_projector_operator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  content
// s_axis    in         tdata: row, column, value, mass, dof_index; tuser: action; tlast: last
// m_axis    out        tdata: hit, out_index, contribution; tuser: saturated; tlast: final_res
// cfg       in         wr_en, wr_index, wr_data (active_projectors, active_hits)
// table writes are taken on accept; samples pass the accept and then a multiply stage
// a last sample runs P*H + P*P + H*P products on one multiplier,
// two drains (none when P is zero) and one emit per hit
// beta and gamma products flow along two chains of MaxProj accumulator cells
// reset clears control and coefficients; tables are undefined until written
// output stalls hold the sequencer; input is blocked while a run is in progress
module separable_projector_operator_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // row[2:0], column[8:3], value[40:9], mass[71:41], dof_index[91:72], zeros
    input  wire logic [95:0]  s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit[5:0], out_index[25:6], contribution[57:26], zeros
    output logic [63:0]       m_axis_tdata,
    // saturated[0]
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         wr_en,
    input  wire logic         wr_index,
    input  wire logic [6:0]   wr_data
);
    localparam int PB = spo_pkg::ProjBits;
    localparam int HB = spo_pkg::HitBits;
    localparam int NP = spo_pkg::MaxProj;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SAMP  = 7'b0000010,
        S_BETA  = 7'b0000100,
        S_GAM   = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] np_cfg_reg;
    logic [6:0] nh_cfg_reg;

    // input fields
    logic [2:0]         in_row;
    logic [5:0]         in_col;
    logic signed [31:0] in_value;
    logic [30:0]        in_mass;
    logic [19:0]        in_dof;
    assign in_row   = s_axis_tdata[2:0];
    assign in_col   = s_axis_tdata[8:3];
    assign in_value = s_axis_tdata[40:9];
    assign in_mass  = s_axis_tdata[71:41];
    assign in_dof   = s_axis_tdata[91:72];

    logic acc_in;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc_in = s_axis_tvalid && s_axis_tready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_cfg_reg <= 4'd8;
            nh_cfg_reg <= 7'd64;
        end
        else if (wr_en)
        begin
            case (wr_index)
                spo_pkg::CfgProj: np_cfg_reg <= wr_data[3:0];
                spo_pkg::CfgHits: nh_cfg_reg <= wr_data;
                default: ;
            endcase
        end
    end

    logic [4:0] np;
    logic [6:0] nh;
    assign np = (np_cfg_reg > 4'd8) ? 5'd8 : {1'b0, np_cfg_reg};
    assign nh = (nh_cfg_reg > 7'd64) ? 7'd64 : nh_cfg_reg;

    // sequencer counters: outer, inner, output slot
    logic [6:0] o_reg, o_next, k_reg, k_next;
    logic [1:0] ph_reg, ph_next;   // sub-step within one product
    logic       last_reg;

    // memories
    logic          pt_we, mx_we, ws_we, pi_we;
    logic [8:0]    pt_wa, pt_ra;
    logic [5:0]    mx_wa, mx_ra, ws_ra, pi_ra;
    logic [31:0]   pt_rd, mx_rd, ws_rd;
    logic [19:0]   pi_rd;
    logic [31:0]   ws_wd;
    logic [5:0]    samp_col_reg;
    logic [19:0]   samp_dof_reg;
    logic signed [62:0] samp_prod_reg;

    spo_ram #(.WIDTH(32), .DEPTH(512)) u_ptab (.clk, .we(pt_we), .waddr(pt_wa),
        .wdata(in_value), .raddr(pt_ra), .rdata(pt_rd));
    spo_ram #(.WIDTH(32), .DEPTH(64)) u_mtx (.clk, .we(mx_we), .waddr(mx_wa),
        .wdata(in_value), .raddr(mx_ra), .rdata(mx_rd));
    spo_ram #(.WIDTH(32), .DEPTH(64)) u_wsmp (.clk, .we(ws_we), .waddr(samp_col_reg),
        .wdata(ws_wd), .raddr(ws_ra), .rdata(ws_rd));
    spo_ram #(.WIDTH(20), .DEPTH(64)) u_pidx (.clk, .we(pi_we), .waddr(samp_col_reg),
        .wdata(samp_dof_reg), .raddr(pi_ra), .rdata(pi_rd));

    assign pt_we = acc_in && s_axis_tuser == spo_pkg::ActProj;
    assign pt_wa = {in_row, in_col};
    assign mx_we = acc_in && s_axis_tuser == spo_pkg::ActMatrix && in_col < 6'd8;
    assign mx_wa = {in_row, in_col[2:0]};

    // weighted sample saturation
    logic signed [38:0] ws_sh;
    assign ws_sh = samp_prod_reg[62:24];
    assign ws_wd = (ws_sh > 39'sd2147483647) ? 32'h7FFF_FFFF :
                   (ws_sh < -39'sd2147483648) ? 32'h8000_0000 : ws_sh[31:0];
    assign ws_we = (state_reg == S_SAMP);
    assign pi_we = (state_reg == S_SAMP);

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            samp_col_reg  <= in_col;
            samp_dof_reg  <= in_dof;
            samp_prod_reg <= $signed({1'b0, in_mass}) * in_value;
        end
    end

    // cell chain feeding
    logic signed [63:0] cacc [NP];
    spo_pkg::mac_op_t   issue_reg;
    logic signed [79:0] prod_reg;
    spo_pkg::mac_op_t   mop_reg, mop_next;
    logic signed [47:0] a_sel;
    logic signed [63:0] gam_sel;

    assign gam_sel  = cacc[k_reg[PB-1:0]];

    // read addresses per phase
    always_comb
    begin
        pt_ra = '0;
        mx_ra = '0;
        ws_ra = '0;
        pi_ra = '0;
        case (state_reg)
            S_BETA:
            begin
                pt_ra = {o_reg[PB-1:0], k_reg[HB-1:0]};
                ws_ra = k_reg[HB-1:0];
            end
            S_GAM:   mx_ra = {o_reg[PB-1:0], k_reg[PB-1:0]};
            S_OUT:
            begin
                pt_ra = {k_reg[PB-1:0], o_reg[HB-1:0]};
                pi_ra = o_reg[HB-1:0];
            end
            default: ;
        endcase
    end

    // beta accumulators and gamma accumulators are two cell rows; output uses a sum reg
    logic signed [63:0] beta_q [NP];
    logic signed [63:0] osum_reg, osum_next;
    logic [19:0]        oidx_reg;

    // operand choice and product issue on sub-step 1 (after registered read)
    always_comb
    begin
        mop_next = '0;
        a_sel    = '0;
        if (ph_reg == 2'd1)
        begin
            case (state_reg)
                S_BETA:
                begin
                    mop_next.vld  = 1'b1;
                    mop_next.clr  = (k_reg == 7'd0);
                    mop_next.done = (k_reg == nh - 7'd1);
                    mop_next.lane = o_reg[PB-1:0];
                    mop_next.a    = {{16{pt_rd[31]}}, pt_rd};
                    mop_next.b    = ws_rd;
                end
                S_GAM:
                begin
                    mop_next.vld  = 1'b1;
                    mop_next.wide = 1'b1;
                    mop_next.clr  = (k_reg == 7'd0);
                    mop_next.done = (k_reg == {2'b0, np} - 7'd1);
                    mop_next.lane = o_reg[PB-1:0];
                    mop_next.a    = beta_q[k_reg[PB-1:0]][47:0];
                    mop_next.b    = mx_rd;
                end
                S_OUT:
                begin
                    mop_next.wide = 1'b1;
                    mop_next.clr  = (k_reg == 7'd0);
                    mop_next.a    = gam_sel[47:0];
                    mop_next.b    = pt_rd;
                end
                default: ;
            endcase
        end
        a_sel = mop_next.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mop_reg <= '0;
        else
            mop_reg <= mop_next;
    end

    // shared multiplier: 48 x 32 cut as (a>>24)*b plus floor((a mod 2^24)*b >> 24)
    logic signed [55:0] hi_prod_reg;
    logic signed [57:0] lo_prod_reg;
    logic signed [23:0] a_hi;
    logic        [23:0] a_lo;
    always_comb
    begin
        a_hi = a_sel[47:24];
        a_lo = a_sel[23:0];
    end
    always_ff @(posedge clk)
    begin
        hi_prod_reg <= a_hi * mop_next.b;
        lo_prod_reg <= $signed({1'b0, a_lo}) * mop_next.b;
    end
    logic signed [79:0] prod_comb;
    assign prod_comb = 80'(hi_prod_reg) + 80'(lo_prod_reg >>> spo_pkg::FracBits);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            issue_reg <= '0;
        else
            issue_reg <= mop_reg.wide ? mop_reg : (mop_reg.vld ? mop_reg : '0);
    end
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_comb;
    end

    // beta row: cells for phase one, gamma row for phase two
    spo_pkg::mac_op_t   bop [NP+1];
    logic signed [79:0] bpr [NP+1];
    spo_pkg::mac_op_t   gop [NP+1];
    logic signed [79:0] gpr [NP+1];
    logic beta_run_reg;

    assign bop[0] = (issue_reg.vld && !issue_reg.wide) ? issue_reg : '0;
    assign gop[0] = (issue_reg.vld && issue_reg.wide)  ? issue_reg : '0;
    assign bpr[0] = prod_reg;
    assign gpr[0] = prod_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NP; gi++)
        begin : g_cells
            spo_cell u_bcell (.clk, .rst_n, .id(PB'(gi)), .op_in(bop[gi]),
                .prod_in(bpr[gi]), .op_out(bop[gi+1]), .prod_out(bpr[gi+1]),
                .acc(beta_q[gi]));
            spo_cell u_gcell (.clk, .rst_n, .id(PB'(gi)), .op_in(gop[gi]),
                .prod_in(gpr[gi]), .op_out(gop[gi+1]), .prod_out(gpr[gi+1]),
                .acc(cacc[gi]));
        end
    endgenerate

    // output contribution sum from the non-cell path, product registered by sub-step 3
    logic out_step;
    assign out_step = (state_reg == S_OUT) && ph_reg == 2'd3 && np != 5'd0;
    always_comb
    begin
        osum_next = osum_reg;
        if (out_step)
            osum_next = (k_reg == 7'd0) ? prod_reg[63:0] : osum_reg + prod_reg[63:0];
    end

    // result register
    logic [63:0] res_data_reg;
    logic        res_sat_reg, res_last_reg, res_vld_reg;
    logic signed [63:0] fsum;
    logic        f_sat;
    logic [31:0] f_val;
    assign fsum = osum_reg;
    always_comb
    begin
        f_sat = 1'b0;
        f_val = fsum[31:0];
        if (fsum > 64'sd2147483647)
        begin
            f_sat = 1'b1;
            f_val = 32'h7FFF_FFFF;
        end
        else if (fsum < -64'sd2147483648)
        begin
            f_sat = 1'b1;
            f_val = 32'h8000_0000;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        o_next     = o_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_in && s_axis_tuser == spo_pkg::ActSample)
                    state_next = S_SAMP;
                o_next  = '0;
                k_next  = '0;
                ph_next = '0;
            end
            S_SAMP:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (nh == 7'd0)
                    state_next = S_IDLE;
                else if (np == 5'd0)
                    state_next = S_OUT;
                else
                    state_next = S_BETA;
            end
            S_BETA, S_GAM:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    ph_next = '0;
                    k_next  = k_reg + 7'd1;
                    if (k_reg == ((state_reg == S_BETA) ? nh : {2'b0, np}) - 7'd1)
                    begin
                        k_next = '0;
                        o_next = o_reg + 7'd1;
                        if (o_reg == {2'b0, np} - 7'd1)
                        begin
                            o_next     = '0;
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    ph_next    = '0;
                    state_next = beta_run_reg ? S_GAM : S_OUT;
                end
            end
            S_OUT:
            begin
                ph_next = ph_reg + 2'd1;
                if (np == 5'd0)
                begin
                    if (ph_reg == 2'd3)
                    begin
                        ph_next    = '0;
                        state_next = S_EMIT;
                    end
                end
                else if (ph_reg == 2'd3)
                begin
                    ph_next = '0;
                    k_next  = k_reg + 7'd1;
                    if (k_reg == {2'b0, np} - 7'd1)
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!res_vld_reg || m_axis_tready)
                begin
                    o_next = o_reg + 7'd1;
                    state_next = (o_reg == nh - 7'd1) ? S_IDLE : S_OUT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic emit_now;
    assign emit_now = (state_reg == S_EMIT) && (!res_vld_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            o_reg        <= '0;
            k_reg        <= '0;
            ph_reg       <= '0;
            last_reg     <= 1'b0;
            beta_run_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            o_reg     <= o_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            if (acc_in)
                last_reg <= s_axis_tlast && (s_axis_tuser == spo_pkg::ActSample);
            if (state_reg == S_SAMP)
                beta_run_reg <= 1'b1;
            else if (state_reg == S_DRAIN && state_next != S_DRAIN)
                beta_run_reg <= 1'b0;
            if (emit_now)
                res_vld_reg <= 1'b1;
            else if (m_axis_tready)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && ph_reg == 2'd1)
            oidx_reg <= pi_rd;
        if (state_reg == S_SAMP || (state_reg == S_DRAIN && !beta_run_reg))
            osum_reg <= '0;
        else
            osum_reg <= osum_next;
        if (emit_now)
        begin
            res_data_reg <= {6'b0, f_val, oidx_reg, o_reg[5:0]};
            res_sat_reg  <= f_sat;
            res_last_reg <= (o_reg == nh - 7'd1);
        end
    end

    assign m_axis_tvalid = res_vld_reg;
    assign m_axis_tdata  = res_data_reg;
    assign m_axis_tuser  = res_sat_reg;
    assign m_axis_tlast  = res_last_reg;
endmodule
`default_nettype wire
